// ----- hdl/sae_pkg.sv -----
package sae_pkg;

    // Defaults for the top-level parameters.
    localparam int IN_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF = 14;

    // Internal fixed point: all intermediate angles and unit vectors are Q30.
    localparam int Q = 30;

    // Status codes.
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ANTI = 2'd2;

    // Pipeline control handed to the arithmetic units.
    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

endpackage

// ----- hdl/sae_if.sv -----
// Input channel: reference and nadir vectors.
interface sae_in_if #(parameter int IN_W = sae_pkg::IN_WIDTH_DEF);
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] ref_x;
    logic [IN_W-1:0] ref_y;
    logic [IN_W-1:0] ref_z;
    logic [IN_W-1:0] nadir_x;
    logic [IN_W-1:0] nadir_y;
    logic [IN_W-1:0] nadir_z;

    modport source (output valid, ref_x, ref_y, ref_z, nadir_x, nadir_y, nadir_z,
                    input ready);
    modport sink (input valid, ref_x, ref_y, ref_z, nadir_x, nadir_y, nadir_z,
                  output ready);
endinterface

// Output channel: error quaternion and status.
interface sae_out_if #(parameter int OUT_W = sae_pkg::FRAC_BITS_DEF + 2);
    logic                          valid;
    logic                          ready;
    logic [OUT_W-1:0]              err_w;
    logic [OUT_W-1:0]              err_x;
    logic [OUT_W-1:0]              err_y;
    logic [OUT_W-1:0]              err_z;
    logic [sae_pkg::STATUS_W-1:0]  status;

    modport source (output valid, err_w, err_x, err_y, err_z, status, input ready);
    modport sink (input valid, err_w, err_x, err_y, err_z, status, output ready);
endinterface

// ----- hdl/sae_sqrt.sv -----
module sae_sqrt #(
    parameter int RAD_W  = 64,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sae_pkg::t_pipe_ctl                i_ctl,
    input  logic [LANES-1:0][RAD_W-1:0]       i_rad,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic [LANES-1:0][RAD_W/2-1:0]     o_root,
    output logic [SIDE_W-1:0]                 o_side,
    output logic                              o_vld
);
    import sae_pkg::*;

    localparam int RT_W  = RAD_W / 2;
    localparam int REM_W = RT_W + 2;

    // One root bit per stage; radicand and side data travel along.
    logic [RT_W-1:0]                          r_vld;
    logic [RT_W-1:0][LANES-1:0][RAD_W-1:0]    r_rad,  n_rad;
    logic [RT_W-1:0][LANES-1:0][REM_W-1:0]    r_rem,  n_rem;
    logic [RT_W-1:0][LANES-1:0][RT_W-1:0]     r_root, n_root;
    logic [RT_W-1:0][SIDE_W-1:0]              r_side, n_side;

    // Digit-by-digit square root step for every stage and lane.
    always_comb begin
        logic [REM_W-1:0] rem_in;
        logic [RT_W-1:0]  root_in;
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] tr;
        for (int k = 0; k < RT_W; k++) begin
            if (k == 0) begin
                n_side[k] = i_side;
            end else begin
                n_side[k] = r_side[k-1];
            end
            for (int l = 0; l < LANES; l++) begin
                if (k == 0) begin
                    n_rad[k][l] = i_rad[l];
                    rem_in      = '0;
                    root_in     = '0;
                end else begin
                    n_rad[k][l] = r_rad[k-1][l];
                    rem_in      = r_rem[k-1][l];
                    root_in     = r_root[k-1][l];
                end
                sh = {rem_in[RT_W-1:0], n_rad[k][l][2*(RT_W-1-k) +: 2]};
                tr = {root_in, 2'b01};
                if (sh >= tr) begin
                    n_rem[k][l]  = sh - tr;
                    n_root[k][l] = {root_in[RT_W-2:0], 1'b1};
                end else begin
                    n_rem[k][l]  = sh;
                    n_root[k][l] = {root_in[RT_W-2:0], 1'b0};
                end
            end
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[RT_W-2:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= n_side;
        end
    end

    assign o_root = r_root[RT_W-1];
    assign o_side = r_side[RT_W-1];
    assign o_vld  = r_vld[RT_W-1];

endmodule

// ----- hdl/sae_div.sv -----
module sae_div #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 31,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sae_pkg::t_pipe_ctl            i_ctl,
    input  logic [LANES-1:0][NUM_W-1:0]   i_num,
    input  logic [LANES-1:0][DEN_W-1:0]   i_den,
    input  logic [SIDE_W-1:0]             i_side,
    output logic [LANES-1:0][QUO_W-1:0]   o_quo,
    output logic [SIDE_W-1:0]             o_side,
    output logic                          o_vld
);
    import sae_pkg::*;

    // Restoring division, one quotient bit per stage. The quotient is known
    // to fit in QUO_W bits, so the bits above start out as the remainder.
    logic [QUO_W-1:0]                         r_vld;
    logic [QUO_W-1:0][LANES-1:0][NUM_W-1:0]   r_num, n_num;
    logic [QUO_W-1:0][LANES-1:0][DEN_W-1:0]   r_den, n_den;
    logic [QUO_W-1:0][LANES-1:0][DEN_W-1:0]   r_rem, n_rem;
    logic [QUO_W-1:0][LANES-1:0][QUO_W-1:0]   r_quo, n_quo;
    logic [QUO_W-1:0][SIDE_W-1:0]             r_side, n_side;

    always_comb begin
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   sh;
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                n_side[k] = i_side;
            end else begin
                n_side[k] = r_side[k-1];
            end
            for (int l = 0; l < LANES; l++) begin
                if (k == 0) begin
                    n_num[k][l] = i_num[l];
                    n_den[k][l] = i_den[l];
                    rem_in      = DEN_W'(i_num[l] >> QUO_W);
                    quo_in      = '0;
                end else begin
                    n_num[k][l] = r_num[k-1][l];
                    n_den[k][l] = r_den[k-1][l];
                    rem_in      = r_rem[k-1][l];
                    quo_in      = r_quo[k-1][l];
                end
                sh = {rem_in, n_num[k][l][QUO_W-1-k]};
                if (sh >= {1'b0, n_den[k][l]}) begin
                    n_rem[k][l] = DEN_W'(sh - {1'b0, n_den[k][l]});
                    n_quo[k][l] = {quo_in[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = DEN_W'(sh);
                    n_quo[k][l] = {quo_in[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[QUO_W-2:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_side <= n_side;
        end
    end

    assign o_quo  = r_quo[QUO_W-1];
    assign o_side = r_side[QUO_W-1];
    assign o_vld  = r_vld[QUO_W-1];

endmodule

// ----- hdl/shortest_arc_error_quaternion.sv -----
// The pipeline depth, which grows with IN_WIDTH, is set by the two root pipelines
// and the two dividers, each of which resolves one result bit per stage.
// Throughput: one beat per cycle; the whole pipeline advances whenever the
// output register is empty or being read.
// Reset clears only the valid bits; data registers are not reset.
module shortest_arc_error_quaternion #(
    parameter int IN_WIDTH  = sae_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = sae_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sae_in_if.sink      i_in,
    sae_out_if.source   o_out
);
    import sae_pkg::*;

    localparam int IW        = IN_WIDTH;
    localparam int OW        = FRAC_BITS + 2;
    localparam int SQ_W      = 2 * IW;          // sum of three squares
    localparam int UQ_W      = Q + 1;           // unit component magnitude
    localparam int UN_W      = IW + Q;          // unit division dividend
    localparam int US_W      = Q + 2;           // signed unit component
    localparam int PR_W      = 2 * US_W;        // product and sum width
    localparam int C_W       = Q + 3;           // signed shrunk dot / cross
    localparam int CM_W      = Q + 2;           // cross component magnitude
    localparam int RAD_W     = 2 * CM_W;        // radicand width
    localparam int RT_W      = CM_W;            // root width
    localparam int OUT_SHIFT = Q - FRAC_BITS;
    localparam logic [CM_W:0] HALF = ((CM_W+1)'(1) << OUT_SHIFT) >> 1;
    localparam logic [CM_W:0] LIM  = (CM_W+1)'(1) << FRAC_BITS;
    localparam logic signed [C_W-1:0] ONE = C_W'(1) << Q;

    typedef struct packed {
        logic [5:0][IW-1:0] mag;
        logic [5:0]         neg;
    } t_nrm_side;

    typedef struct packed {
        logic [5:0] neg;
        logic       zero;
    } t_unit_side;

    typedef struct packed {
        logic [2:0][CM_W-1:0] cm;
        logic [2:0]           cneg;
        logic                 cn;
        logic                 zero;
    } t_ang_side;

    typedef struct packed {
        logic [RT_W-1:0] w;
        logic [2:0]      cneg;
        logic            lz;
        logic            cn;
        logic            zero;
    } t_axis_side;

    // Truncate a Q60 value toward zero into Q30.
    function automatic logic signed [C_W-1:0] shrink(logic signed [PR_W-1:0] v);
        logic [PR_W-1:0] m;
        logic [C_W-1:0]  s;
        m = v[PR_W-1] ? $unsigned(-v) : $unsigned(v);
        s = C_W'(m >> Q);
        return v[PR_W-1] ? $signed(-s) : $signed(s);
    endfunction

    // Round a Q30 magnitude half up to the output scale, saturate, apply sign.
    function automatic logic [OW-1:0] to_out(logic [CM_W-1:0] m, logic neg);
        logic [CM_W:0] r;
        r = ({1'b0, m} + HALF) >> OUT_SHIFT;
        if (r > LIM) begin
            r = LIM;
        end
        return neg ? OW'(-r) : OW'(r);
    endfunction

    logic r_out_vld;
    logic en;
    assign en = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // Stage 0: magnitudes and signs of the input components.
    logic                    r0_vld;
    logic [5:0][IW-1:0]      r0_mag;
    logic [5:0]              r0_neg;
    logic [5:0][IW-1:0]      raw;
    assign raw = {i_in.nadir_z, i_in.nadir_y, i_in.nadir_x,
                  i_in.ref_z, i_in.ref_y, i_in.ref_x};

    // Stage 1: squares. Stage 2: sums of squares.
    logic                    r1_vld, r2_vld;
    logic [5:0][SQ_W-1:0]    r1_sq;
    logic [5:0][IW-1:0]      r1_mag, r2_mag;
    logic [5:0]              r1_neg, r2_neg;
    logic [1:0][SQ_W-1:0]    r2_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                r0_neg[i] <= raw[i][IW-1];
                r0_mag[i] <= raw[i][IW-1] ? IW'(~raw[i] + 1'b1) : raw[i];
                r1_sq[i]  <= SQ_W'(r0_mag[i]) * SQ_W'(r0_mag[i]);
            end
            r1_mag    <= r0_mag;
            r1_neg    <= r0_neg;
            r2_sum[0] <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            r2_sum[1] <= r1_sq[3] + r1_sq[4] + r1_sq[5];
            r2_mag    <= r1_mag;
            r2_neg    <= r1_neg;
        end
    end

    // Vector lengths.
    t_nrm_side               nrm_side_in, nrm_side;
    logic [1:0][IW-1:0]      len;
    logic                    nrm_vld;
    assign nrm_side_in = '{mag: r2_mag, neg: r2_neg};

    sae_sqrt #(.RAD_W(SQ_W), .LANES(2), .SIDE_W($bits(t_nrm_side))) u_nrm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: en, vld: r2_vld}),
        .i_rad   (r2_sum),
        .i_side  (nrm_side_in),
        .o_root  (len),
        .o_side  (nrm_side),
        .o_vld   (nrm_vld)
    );

    // Unit vectors: each magnitude times 2^30 over its vector's length.
    logic [5:0][UN_W-1:0]    unum;
    logic [5:0][IW-1:0]      uden;
    t_unit_side              unit_side_in, unit_side;
    logic [5:0][UQ_W-1:0]    uq;
    logic                    unit_vld;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            unum[i] = {nrm_side.mag[i], Q'(0)};
            uden[i] = (i < 3) ? len[0] : len[1];
        end
        unit_side_in.neg  = nrm_side.neg;
        unit_side_in.zero = (len[0] == '0) || (len[1] == '0);
    end

    sae_div #(
        .NUM_W(UN_W), .DEN_W(IW), .QUO_W(UQ_W), .LANES(6),
        .SIDE_W($bits(t_unit_side))
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: en, vld: nrm_vld}),
        .i_num   (unum),
        .i_den   (uden),
        .i_side  (unit_side_in),
        .o_quo   (uq),
        .o_side  (unit_side),
        .o_vld   (unit_vld)
    );

    // Stages 3 to 8: signed units, products, sums, shrink and clamp,
    // squares of the cross product and half-angle radicands, their sum.
    logic                           r3_vld, r4_vld, r5_vld, r6_vld, r7_vld, r8_vld;
    logic signed [US_W-1:0]         r3_u [6];
    logic signed [PR_W-1:0]         r4_d [3];
    logic signed [PR_W-1:0]         r4_x [6];
    logic signed [PR_W-1:0]         r5_dot;
    logic signed [PR_W-1:0]         r5_cr [3];
    logic signed [C_W-1:0]          r6_c;
    logic signed [C_W-1:0]          r6_cr [3];
    logic [2:0][RAD_W-1:0]          r7_csq;
    logic [2:0][CM_W-1:0]           r7_cm, r8_cm;
    logic [2:0]                     r7_cneg, r8_cneg;
    logic [RAD_W-1:0]               r7_wrad, r7_srad, r8_wrad, r8_srad, r8_lrad;
    logic                           r7_cn, r8_cn;
    logic                           r3_zero, r4_zero, r5_zero, r6_zero, r7_zero, r8_zero;
    logic signed [C_W-1:0]          c_clamp;
    logic signed [C_W:0]            wsum, ssum;

    always_comb begin
        logic signed [C_W-1:0] cs;
        cs = shrink(r5_dot);
        if (cs > ONE) begin
            c_clamp = ONE;
        end else if (cs < -ONE) begin
            c_clamp = -ONE;
        end else begin
            c_clamp = cs;
        end
        wsum = (C_W+1)'(ONE) + (C_W+1)'(r6_c);
        ssum = (C_W+1)'(ONE) - (C_W+1)'(r6_c);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                r3_u[i] <= unit_side.neg[i] ? -US_W'(uq[i]) : US_W'(uq[i]);
            end
            r3_zero <= unit_side.zero;
            // u[0..2] is the reference, u[3..5] the nadir; cross is nadir x ref.
            for (int i = 0; i < 3; i++) begin
                r4_d[i] <= PR_W'(r3_u[i]) * PR_W'(r3_u[i+3]);
            end
            r4_x[0] <= PR_W'(r3_u[4]) * PR_W'(r3_u[2]);
            r4_x[1] <= PR_W'(r3_u[5]) * PR_W'(r3_u[1]);
            r4_x[2] <= PR_W'(r3_u[5]) * PR_W'(r3_u[0]);
            r4_x[3] <= PR_W'(r3_u[3]) * PR_W'(r3_u[2]);
            r4_x[4] <= PR_W'(r3_u[3]) * PR_W'(r3_u[1]);
            r4_x[5] <= PR_W'(r3_u[4]) * PR_W'(r3_u[0]);
            r4_zero <= r3_zero;
            r5_dot   <= r4_d[0] + r4_d[1] + r4_d[2];
            r5_cr[0] <= r4_x[0] - r4_x[1];
            r5_cr[1] <= r4_x[2] - r4_x[3];
            r5_cr[2] <= r4_x[4] - r4_x[5];
            r5_zero  <= r4_zero;
            r6_c    <= c_clamp;
            for (int i = 0; i < 3; i++) begin
                r6_cr[i] <= shrink(r5_cr[i]);
            end
            r6_zero <= r5_zero;
            for (int i = 0; i < 3; i++) begin
                r7_cneg[i] <= r6_cr[i][C_W-1];
                r7_cm[i]   <= CM_W'(r6_cr[i][C_W-1] ? $unsigned(-r6_cr[i])
                                                      : $unsigned(r6_cr[i]));
                r7_csq[i]  <= RAD_W'(CM_W'(r6_cr[i][C_W-1] ? $unsigned(-r6_cr[i])
                                                           : $unsigned(r6_cr[i])))
                            * RAD_W'(CM_W'(r6_cr[i][C_W-1] ? $unsigned(-r6_cr[i])
                                                           : $unsigned(r6_cr[i])));
            end
            r7_wrad <= RAD_W'($unsigned(wsum)) << (Q - 1);
            r7_srad <= RAD_W'($unsigned(ssum)) << (Q - 1);
            r7_cn   <= r6_c[C_W-1];
            r7_zero <= r6_zero;
            r8_lrad <= r7_csq[0] + r7_csq[1] + r7_csq[2];
            r8_wrad <= r7_wrad;
            r8_srad <= r7_srad;
            r8_cm   <= r7_cm;
            r8_cneg <= r7_cneg;
            r8_cn   <= r7_cn;
            r8_zero <= r7_zero;
        end
    end

    // Half-angle cosine, sine and cross product length in one root pipeline.
    t_ang_side               ang_side_in, ang_side;
    logic [2:0][RT_W-1:0]    roots;
    logic                    ang_vld;
    assign ang_side_in = '{cm: r8_cm, cneg: r8_cneg, cn: r8_cn, zero: r8_zero};

    sae_sqrt #(.RAD_W(RAD_W), .LANES(3), .SIDE_W($bits(t_ang_side))) u_ang (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: en, vld: r8_vld}),
        .i_rad   ({r8_lrad, r8_srad, r8_wrad}),
        .i_side  (ang_side_in),
        .o_root  (roots),
        .o_side  (ang_side),
        .o_vld   (ang_vld)
    );

    // Stage 9: cross components scaled by the half-angle sine.
    logic                        r9_vld;
    logic [2:0][RAD_W-1:0]       r9_vn;
    logic [2:0][RT_W-1:0]        r9_len;
    t_axis_side                  r9_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r9_vn[i]  <= RAD_W'(ang_side.cm[i]) * RAD_W'(roots[1]);
                r9_len[i] <= roots[2];
            end
            r9_side.w    <= roots[0];
            r9_side.cneg <= ang_side.cneg;
            r9_side.lz   <= (roots[2] == '0);
            r9_side.cn   <= ang_side.cn;
            r9_side.zero <= ang_side.zero;
        end
    end

    // Unit axis times sine: divide by the cross product length.
    t_axis_side              axis_side;
    logic [2:0][UQ_W-1:0]    vq;
    logic                    axis_vld;

    sae_div #(
        .NUM_W(RAD_W), .DEN_W(RT_W), .QUO_W(UQ_W), .LANES(3),
        .SIDE_W($bits(t_axis_side))
    ) u_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: en, vld: r9_vld}),
        .i_num   (r9_vn),
        .i_den   (r9_len),
        .i_side  (r9_side),
        .o_quo   (vq),
        .o_side  (axis_side),
        .o_vld   (axis_vld)
    );

    // Output register: special cases, rounding and saturation.
    logic [OW-1:0]           r_w, r_x, r_y, r_z;
    logic [STATUS_W-1:0]     r_status;
    logic [OW-1:0]           n_w, n_x, n_y, n_z;
    logic [STATUS_W-1:0]     n_status;

    always_comb begin
        n_w = to_out(axis_side.w, 1'b0);
        n_x = to_out(CM_W'(vq[0]), axis_side.cneg[0]);
        n_y = to_out(CM_W'(vq[1]), axis_side.cneg[1]);
        n_z = to_out(CM_W'(vq[2]), axis_side.cneg[2]);
        n_status = ST_OK;
        if (axis_side.zero) begin
            n_w      = OW'(LIM);
            n_x      = '0;
            n_y      = '0;
            n_z      = '0;
            n_status = ST_ZERO;
        end else if (axis_side.lz) begin
            n_x = '0;
            n_y = '0;
            n_z = '0;
            if (axis_side.cn) begin
                n_w      = '0;
                n_status = ST_ANTI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w      <= n_w;
            r_x      <= n_x;
            r_y      <= n_y;
            r_z      <= n_z;
            r_status <= n_status;
        end
    end

    // Valid bits of the local stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld    <= 1'b0;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r0_vld    <= i_in.valid;
            r1_vld    <= r0_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= unit_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r9_vld    <= ang_vld;
            r_out_vld <= axis_vld;
        end
    end

    assign o_out.valid  = r_out_vld;
    assign o_out.err_w  = r_w;
    assign o_out.err_x  = r_x;
    assign o_out.err_y  = r_y;
    assign o_out.err_z  = r_z;
    assign o_out.status = r_status;

    // A zero-length input always yields the identity quaternion.
    a_zero_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_ZERO |->
            o_out.err_w == OW'(LIM) && o_out.err_x == '0 &&
            o_out.err_y == '0 && o_out.err_z == '0)
        else $error("zero-length beat without identity quaternion");

    // Antiparallel vectors give an all-zero quaternion.
    a_anti_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_ANTI |->
            o_out.err_w == '0 && o_out.err_x == '0 &&
            o_out.err_y == '0 && o_out.err_z == '0)
        else $error("antiparallel beat with nonzero quaternion");

    // The scalar part is a half-angle cosine and never negative.
    a_w_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !o_out.err_w[OW-1])
        else $error("negative scalar part");

endmodule
